// ===== sv/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; used by every module of the block.
`default_nettype none

package uer_pkg;

  localparam int unsigned CntBits   = 8;
  localparam int unsigned TrigBits  = 16;
  localparam int unsigned ScaleBits = 17;
  localparam int unsigned DistBits  = 8;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned ProdBits  = CntBits + ScaleBits;
  localparam int unsigned AddrBits  = 4;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] RegTrigCycles = 2'd0;
  localparam logic [1:0] RegScaleQ16   = 2'd1;
  localparam logic [1:0] RegMinCm      = 2'd2;
  localparam logic [1:0] RegMaxCm      = 2'd3;

  localparam logic [TrigBits-1:0]  TrigCyclesRst = 16'd160;
  localparam logic [ScaleBits-1:0] ScaleQ16Rst   = 17'd71959;
  localparam logic [DistBits-1:0]  MinCmRst      = 8'd5;
  localparam logic [DistBits-1:0]  MaxCmRst      = 8'd200;

  typedef struct packed {
    logic start_req;
    logic echo;
    logic tick;
  } in_item_t;

  typedef struct packed {
    logic                trig;
    logic                done_res;
    logic [DistBits-1:0] meas_cm;
    logic                in_range;
    logic                read_error;
  } out_item_t;

  // What the sequencer reports for the request being taken this cycle
  typedef struct packed {
    logic               trig;
    logic               done;
    logic [CntBits-1:0] rise;
    logic [CntBits-1:0] fall;
  } meas_t;

  typedef struct packed {
    logic [DistBits-1:0] cm;
    logic                in_range;
    logic                err;
  } dist_res_t;

endpackage

`default_nettype wire

// ===== sv/uer_ctrl.sv =====
// Measurement sequencer: phase, trigger countdown, wrapping timer, rise capture.
// Depends on uer_pkg.
`default_nettype none

module uer_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire uer_pkg::in_item_t             item,
  input  wire logic [uer_pkg::TrigBits-1:0]  trigger_cycles,
  output uer_pkg::meas_t                     meas
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_RISE,
    PH_FALL
  } phase_t;

  phase_t                        phase, phase_next;
  logic [uer_pkg::TrigBits-1:0]  trigger_left, trigger_left_next;
  logic [uer_pkg::CntBits-1:0]   timer_count, timer_count_next;
  logic [uer_pkg::CntBits-1:0]   rise_capture, rise_capture_next;
  logic [uer_pkg::TrigBits-1:0]  trig_len;
  logic                          cleared;

  always_comb begin
    phase_next        = phase;
    trigger_left_next = trigger_left;
    rise_capture_next = rise_capture;
    cleared           = 1'b0;
    meas.trig         = 1'b0;
    meas.done         = 1'b0;
    meas.rise         = rise_capture;
    meas.fall         = timer_count;
    // a zero length is replaced by the shortest nonzero length
    trig_len = (trigger_cycles == '0) ? {{(uer_pkg::TrigBits-1){1'b0}}, 1'b1} : trigger_cycles;
    unique case (phase)
      PH_IDLE: begin
        if (item.start_req) begin
          meas.trig         = 1'b1;
          cleared           = 1'b1;
          trigger_left_next = trig_len - {{(uer_pkg::TrigBits-1){1'b0}}, 1'b1};
          phase_next        = (trigger_left_next != '0) ? PH_TRIG : PH_RISE;
        end
      end
      PH_TRIG: begin
        meas.trig = 1'b1;
        if (trigger_left != '0) begin
          trigger_left_next = trigger_left - {{(uer_pkg::TrigBits-1){1'b0}}, 1'b1};
        end
        if (trigger_left_next == '0) begin
          phase_next = PH_RISE;
        end
      end
      PH_RISE: begin
        if (item.echo) begin
          rise_capture_next = timer_count;
          phase_next        = PH_FALL;
        end
      end
      PH_FALL: begin
        if (!item.echo) begin
          meas.done  = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
    if (cleared) begin
      timer_count_next = '0;
    end else if (item.tick) begin
      timer_count_next = timer_count + {{(uer_pkg::CntBits-1){1'b0}}, 1'b1};
    end else begin
      timer_count_next = timer_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      trigger_left <= '0;
      timer_count  <= '0;
      rise_capture <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      trigger_left <= trigger_left_next;
      timer_count  <= timer_count_next;
      rise_capture <= rise_capture_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/uer_dist.sv =====
// Echo width to distance: Q16 scale, round half up, saturate, range check.
// Depends on uer_pkg.
`default_nettype none

module uer_dist (
  input  wire logic [uer_pkg::CntBits-1:0]   rise,
  input  wire logic [uer_pkg::CntBits-1:0]   fall,
  input  wire logic [uer_pkg::ScaleBits-1:0] scale_q16,
  input  wire logic [uer_pkg::DistBits-1:0]  min_cm,
  input  wire logic [uer_pkg::DistBits-1:0]  max_cm,
  output uer_pkg::dist_res_t                 res
);

  logic [uer_pkg::CntBits-1:0]  width;
  logic [uer_pkg::ProdBits:0]   prod;
  logic [uer_pkg::ProdBits-uer_pkg::FracBits:0] whole;
  logic [uer_pkg::DistBits-1:0] sat_cm;
  logic                         ok;

  always_comb begin
    ok    = fall > rise;
    width = fall - rise;
    prod  = ({1'b0, width, {uer_pkg::ScaleBits{1'b0}}} >> uer_pkg::ScaleBits)
            * {{(uer_pkg::CntBits+1){1'b0}}, scale_q16}
            + {{(uer_pkg::ProdBits-uer_pkg::FracBits+1){1'b0}}, 1'b1,
               {(uer_pkg::FracBits-1){1'b0}}};
    whole = prod[uer_pkg::ProdBits:uer_pkg::FracBits];
    // saturate at the top of the distance range
    if (whole[uer_pkg::ProdBits-uer_pkg::FracBits:uer_pkg::DistBits] != '0) begin
      sat_cm = '1;
    end else begin
      sat_cm = whole[uer_pkg::DistBits-1:0];
    end
    res.err      = !ok;
    res.cm       = ok ? sat_cm : '0;
    res.in_range = ok && (sat_cm >= min_cm) && (sat_cm <= max_cm);
  end

endmodule

`default_nettype wire

// ===== sv/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger: one result per request, one request per cycle while out_data drains.
// Output: a result is registered into out_data when its request is taken and shows there in the next cycle.
// Throughput: one request per cycle, limited only by the output register draining.
// Reset (rst, synchronous): idle phase, timer and captures zero, registers to defaults.
// Depends on uer_pkg, uer_ctrl, uer_dist.
`default_nettype none

module ultrasonic_echo_ranger (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire uer_pkg::in_item_t             in_data,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      uer_pkg::out_item_t            out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [uer_pkg::AddrBits-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready
);

  logic [uer_pkg::TrigBits-1:0]  trigger_cycles;
  logic [uer_pkg::ScaleBits-1:0] scale_q16;
  logic [uer_pkg::DistBits-1:0]  min_cm;
  logic [uer_pkg::DistBits-1:0]  max_cm;
  logic [uer_pkg::DistBits-1:0]  last_distance, last_distance_next;
  logic                          accept;
  logic [1:0]                    reg_idx;
  uer_pkg::meas_t                meas;
  uer_pkg::dist_res_t            dres;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[3:2];
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_cycles <= uer_pkg::TrigCyclesRst;
      scale_q16      <= uer_pkg::ScaleQ16Rst;
      min_cm         <= uer_pkg::MinCmRst;
      max_cm         <= uer_pkg::MaxCmRst;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        uer_pkg::RegTrigCycles: trigger_cycles <= pwdata[uer_pkg::TrigBits-1:0];
        uer_pkg::RegScaleQ16:   scale_q16      <= pwdata[uer_pkg::ScaleBits-1:0];
        uer_pkg::RegMinCm:      min_cm         <= pwdata[uer_pkg::DistBits-1:0];
        uer_pkg::RegMaxCm:      max_cm         <= pwdata[uer_pkg::DistBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      uer_pkg::RegTrigCycles: prdata = {{(32-uer_pkg::TrigBits){1'b0}}, trigger_cycles};
      uer_pkg::RegScaleQ16:   prdata = {{(32-uer_pkg::ScaleBits){1'b0}}, scale_q16};
      uer_pkg::RegMinCm:      prdata = {{(32-uer_pkg::DistBits){1'b0}}, min_cm};
      uer_pkg::RegMaxCm:      prdata = {{(32-uer_pkg::DistBits){1'b0}}, max_cm};
      default:                prdata = '0;
    endcase
  end

  uer_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (in_data),
    .trigger_cycles (trigger_cycles),
    .meas           (meas)
  );

  uer_dist u_dist (
    .rise      (meas.rise),
    .fall      (meas.fall),
    .scale_q16 (scale_q16),
    .min_cm    (min_cm),
    .max_cm    (max_cm),
    .res       (dres)
  );

  assign last_distance_next = meas.done ? dres.cm : last_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      last_distance <= '0;
    end else if (accept) begin
      out_valid     <= 1'b1;
      last_distance <= last_distance_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.trig        <= meas.trig;
      out_data.done_res    <= meas.done;
      out_data.meas_cm     <= last_distance_next;
      out_data.in_range    <= meas.done && dres.in_range;
      out_data.read_error  <= meas.done && dres.err;
    end
  end

endmodule

`default_nettype wire

// ===== sv/uer_checker.sv =====
// Port-level checks for the ultrasonic echo ranger, bound to the top level.
// Depends on uer_pkg and ultrasonic_echo_ranger.
`default_nettype none

module uer_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire uer_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire uer_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_done_no_trig: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.trig)
    else $error("completion while trigger high");

  a_err_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.read_error |->
      out_data.done_res && out_data.meas_cm == '0 && !out_data.in_range)
    else $error("bad error result");

  a_range_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.in_range |-> out_data.done_res && !out_data.read_error)
    else $error("in_range without clean completion");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

`default_nettype wire
